/* hw/rtl/dlt_pkg.sv */
package dlt_pkg;

   localparam int CLIENT_W = 32;
   localparam int INDEX_W  = 6;
   localparam int DEVCNT_W = 5;
   // Wide enough to hold any device count up to the largest table of 64 entries.
   localparam int CNT_W    = 7;

   localparam logic [CLIENT_W-1:0] NO_OWNER     = 32'hDEAD_BEEF;
   localparam logic [DEVCNT_W-1:0] DEVICES_RST  = 5'd16;

   typedef enum logic [1:0] {
      OP_TRYLOCK = 2'd0,
      OP_CHECK   = 2'd1,
      OP_UNLOCK  = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

/* hw/rtl/dlt_req_if.sv */
interface dlt_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic [dlt_pkg::INDEX_W-1:0]   device_index;
   logic [dlt_pkg::CLIENT_W-1:0]  requester;

   modport source (output valid, opcode, device_index, requester, input ready);
   modport sink   (input valid, opcode, device_index, requester, output ready);
endinterface

/* hw/rtl/dlt_rsp_if.sv */
interface dlt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [dlt_pkg::CLIENT_W-1:0]  owner;

   modport source (output valid, ok, owner, input ready);
   modport sink   (input valid, ok, owner, output ready);
endinterface

/* hw/rtl/device_lock_table.sv */
// Device lock table: one lock per device entry, each with an owner client id.
// Requests arrive on req_bus (opcode, device_index, requester); every request
// returns exactly one beat on rsp_bus (ok, owner). csr_wr_en/csr_wr_data set
// the number of device entries in use; write it only while the block is idle.
//
// Try-lock, check and unlock read the owner memory as the request is accepted,
// then decide, write back and register the response in the exec state, which
// waits while the output register is full. Clear-client walks the entries in
// use one per cycle through the same memory read port, then answers in finish.
// One request is in flight at a time; req_bus.ready is high only in the idle
// state. The response sits in an output register, so the next request is
// accepted while a finished response still waits for rsp_bus.ready.
//
// Reset (synchronous, active high) unlocks every entry at once through the
// flip-flop locked flags and restores a device count of 16. The owner memory
// is not cleared; an owner is only ever read for a locked entry.
// If the receiver stalls with a response still held, the next request's
// result waits in its final state until the output register frees up.
module device_lock_table #(
   parameter int MAX_DEVICES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   dlt_req_if.sink                         req_bus,
   dlt_rsp_if.source                       rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [dlt_pkg::DEVCNT_W-1:0]    csr_wr_data
);

   localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int CNT_W = dlt_pkg::CNT_W;
   localparam int CW    = dlt_pkg::CLIENT_W;

   // Control state.
   dlt_pkg::state_type          state_ff, state_in;
   logic [dlt_pkg::DEVCNT_W-1:0] devices_ff;
   logic [MAX_DEVICES-1:0]      locked_ff, locked_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Request context held for the duration of one request.
   dlt_pkg::op_type             op_ff, op_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CW-1:0]               client_ff, client_in;
   logic                        in_range_ff, in_range_in;
   logic [IDX_W-1:0]            cmp_ptr_ff, cmp_ptr_in;
   logic                        found_ff, found_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [CW-1:0]               rsp_owner_ff, rsp_owner_in;

   // Owner memory with one registered read port and one write port.
   logic [CW-1:0]               owner_mem [MAX_DEVICES];
   logic [CW-1:0]               rd_data_ff;
   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic                        wr_en;
   logic [IDX_W-1:0]            wr_addr;
   logic [CW-1:0]               wr_data;

   logic [CNT_W-1:0]            count;
   logic                        req_ready;
   logic                        req_fire;
   logic                        rsp_free;
   logic                        entry_locked;
   logic                        owner_match;
   logic                        scan_hit;
   logic [CNT_W-1:0]            next_ptr;

   // A device count above the table size counts as the table size.
   assign count = ({2'b00, devices_ff} > CNT_W'(MAX_DEVICES)) ? CNT_W'(MAX_DEVICES)
                                                               : {2'b00, devices_ff};

   assign req_ready     = (state_ff == dlt_pkg::ST_IDLE);
   assign req_bus.ready = req_ready;
   assign req_fire      = req_bus.valid && req_ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign entry_locked = locked_ff[idx_ff];
   assign owner_match  = (rd_data_ff == client_ff);
   assign scan_hit     = locked_ff[cmp_ptr_ff] && owner_match;
   assign next_ptr     = CNT_W'(cmp_ptr_ff) + CNT_W'(1);

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.ok    = rsp_ok_ff;
   assign rsp_bus.owner = rsp_owner_ff;

   always_comb begin
      state_in     = state_ff;
      locked_in    = locked_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      client_in    = client_ff;
      in_range_in  = in_range_ff;
      cmp_ptr_in   = cmp_ptr_ff;
      found_in     = found_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_owner_in = rsp_owner_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = client_ff;

      case (state_ff)
         dlt_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in       = dlt_pkg::op_type'(req_bus.opcode);
               idx_in      = req_bus.device_index[IDX_W-1:0];
               client_in   = req_bus.requester;
               in_range_in = ({1'b0, req_bus.device_index} < count);
               if (dlt_pkg::op_type'(req_bus.opcode) == dlt_pkg::OP_CLEAR) begin
                  cmp_ptr_in = '0;
                  found_in   = 1'b0;
                  if (count != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = dlt_pkg::ST_SCAN;
                  end else begin
                     state_in = dlt_pkg::ST_FINISH;
                  end
               end else begin
                  rd_en    = in_range_in;
                  rd_addr  = req_bus.device_index[IDX_W-1:0];
                  state_in = dlt_pkg::ST_EXEC;
               end
            end
         end

         dlt_pkg::ST_EXEC: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_owner_in = '0;
               state_in     = dlt_pkg::ST_IDLE;
               if (in_range_ff) begin
                  case (op_ff)
                     dlt_pkg::OP_TRYLOCK: begin
                        if (entry_locked) begin
                           rsp_ok_in = owner_match;
                        end else begin
                           rsp_ok_in         = 1'b1;
                           locked_in[idx_ff] = 1'b1;
                           wr_en             = 1'b1;
                           wr_data           = client_ff;
                        end
                     end
                     dlt_pkg::OP_CHECK: begin
                        if (entry_locked) begin
                           rsp_ok_in    = 1'b1;
                           rsp_owner_in = rd_data_ff;
                        end
                     end
                     dlt_pkg::OP_UNLOCK: begin
                        if (!entry_locked) begin
                           rsp_ok_in = 1'b1;
                        end else if (owner_match) begin
                           rsp_ok_in         = 1'b1;
                           locked_in[idx_ff] = 1'b0;
                           wr_en             = 1'b1;
                           wr_data           = dlt_pkg::NO_OWNER;
                        end
                     end
                     default: begin
                        rsp_ok_in = 1'b0;
                     end
                  endcase
               end
            end
         end

         dlt_pkg::ST_SCAN: begin
            // The entry at cmp_ptr is on the read data; the next one is read now.
            if (scan_hit) begin
               locked_in[cmp_ptr_ff] = 1'b0;
               wr_en                 = 1'b1;
               wr_addr               = cmp_ptr_ff;
               wr_data               = dlt_pkg::NO_OWNER;
               found_in              = 1'b1;
            end
            if (next_ptr < count) begin
               rd_en      = 1'b1;
               rd_addr    = next_ptr[IDX_W-1:0];
               cmp_ptr_in = next_ptr[IDX_W-1:0];
            end else begin
               state_in = dlt_pkg::ST_FINISH;
            end
         end

         dlt_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = found_ff;
               rsp_owner_in = '0;
               state_in     = dlt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dlt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlt_pkg::ST_IDLE;
         devices_ff   <= dlt_pkg::DEVICES_RST;
         locked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         locked_ff    <= locked_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            devices_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      client_ff    <= client_in;
      in_range_ff  <= in_range_in;
      cmp_ptr_ff   <= cmp_ptr_in;
      found_ff     <= found_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_owner_ff <= rsp_owner_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= owner_mem[rd_addr];
      end
      if (wr_en) begin
         owner_mem[wr_addr] <= wr_data;
      end
   end

   // A request never completes in the cycle it is accepted.
   a_no_same_cycle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != dlt_pkg::ST_IDLE)
      else $error("request left idle state without a processing cycle");

   // The scan pointer stays inside the entries in use.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == dlt_pkg::ST_SCAN |-> CNT_W'(cmp_ptr_ff) < count)
      else $error("clear scan beyond device count");

   // A response beat is only loaded from a deciding state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(state_ff) == dlt_pkg::ST_EXEC || $past(state_ff) == dlt_pkg::ST_FINISH)
      else $error("response raised outside exec or finish");

   // A granted try-lock leaves its entry locked.
   a_lock_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dlt_pkg::ST_EXEC && rsp_free && in_range_ff &&
       op_ff == dlt_pkg::OP_TRYLOCK) |=> locked_ff[$past(idx_ff)])
      else $error("try-lock did not leave entry locked");

endmodule

/* verif/tb_device_lock_table.sv */
module tb_device_lock_table;

   localparam int MAX_DEVICES = 16;
   // Length of the deliberate receiver hold-off, long enough to back the block up.
   localparam int LONG_HOLD   = 200;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int STALL_LIMIT = 3000;

   localparam logic [dlt_pkg::CLIENT_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
   localparam logic [dlt_pkg::CLIENT_W-1:0] TAG_CLIENT = 32'h1234_5678;

   // One request beat and one response beat, as the testbench tracks them.
   typedef struct packed {
      dlt_pkg::op_type                opcode;
      logic [dlt_pkg::INDEX_W-1:0]    device_index;
      logic [dlt_pkg::CLIENT_W-1:0]   requester;
   } lock_req_type;

   typedef struct packed {
      logic                           ok;
      logic [dlt_pkg::CLIENT_W-1:0]   owner;
   } lock_rsp_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [dlt_pkg::DEVCNT_W-1:0]   csr_wr_data;

   dlt_req_if req_bus ();
   dlt_rsp_if rsp_bus ();

   device_lock_table #(
      .MAX_DEVICES (MAX_DEVICES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the lock table, kept in step with every accepted request.
   logic                           entry_locked [MAX_DEVICES];
   logic [dlt_pkg::CLIENT_W-1:0]   entry_owner  [MAX_DEVICES];
   logic [dlt_pkg::DEVCNT_W-1:0]   device_count;

   // Requests waiting to be driven, and responses the block still owes us.
   lock_req_type          pending_requests [$];
   lock_rsp_type          lock_results_due [$];

   int unsigned           queued_total = 0;
   int unsigned           error_count = 0;
   int unsigned           quiet_cycles = 0;

   // Sender pacing: gap after each item, and stretches where gaps are switched off.
   int unsigned           tx_gap;
   int unsigned           tx_stretch;
   logic                  tx_calm;
   lock_req_type          tx_item;

   // Receiver pacing, plus the long hold-offs that the stimulus asks for.
   int unsigned           rx_gap;
   int unsigned           rx_stretch;
   logic                  rx_calm;
   int unsigned           rx_hold;
   int unsigned           holds_asked = 0;
   int unsigned           holds_granted;

   // Monitor scratch.
   lock_req_type          seen_req;
   lock_rsp_type          due_rsp;
   int unsigned           slot;

   // Applies one request to the shadow table and returns the response it must produce.
   // Counts above the table size behave as the full table; entries beyond the
   // count are never touched, so they keep their contents across count changes.
   function automatic lock_rsp_type predict_lock_result(lock_req_type r);
      lock_rsp_type res;
      int unsigned  span;
      int unsigned  e;
      res  = '0;
      span = (32'(device_count) > MAX_DEVICES) ? MAX_DEVICES : 32'(device_count);
      if (r.opcode == dlt_pkg::OP_CLEAR) begin
         for (e = 0; e < span; e++) begin
            if (entry_locked[e] && entry_owner[e] == r.requester) begin
               entry_locked[e] = 1'b0;
               entry_owner[e]  = dlt_pkg::NO_OWNER;
               res.ok          = 1'b1;
            end
         end
      end else if (32'(r.device_index) < span) begin
         e = 32'(r.device_index);
         case (r.opcode)
            dlt_pkg::OP_TRYLOCK: begin
               if (!entry_locked[e]) begin
                  entry_locked[e] = 1'b1;
                  entry_owner[e]  = r.requester;
                  res.ok          = 1'b1;
               end else begin
                  res.ok = (entry_owner[e] == r.requester);
               end
            end
            dlt_pkg::OP_CHECK: begin
               if (entry_locked[e]) begin
                  res.ok    = 1'b1;
                  res.owner = entry_owner[e];
               end
            end
            default: begin
               // Unlock: a free entry succeeds as is; a held one only for its owner.
               if (!entry_locked[e]) begin
                  res.ok = 1'b1;
               end else if (entry_owner[e] == r.requester) begin
                  entry_locked[e] = 1'b0;
                  entry_owner[e]  = dlt_pkg::NO_OWNER;
                  res.ok          = 1'b1;
               end
            end
         endcase
      end
      return res;
   endfunction

   // Mostly back-to-back, often a short gap, now and then a long pause.
   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end else begin
         return $urandom_range(20, 60);
      end
   endfunction

   task automatic queue_request(dlt_pkg::op_type op, int unsigned idx,
                                logic [dlt_pkg::CLIENT_W-1:0] client);
      lock_req_type r;
      r.opcode       = op;
      r.device_index = dlt_pkg::INDEX_W'(idx);
      r.requester    = client;
      pending_requests.push_back(r);
      queued_total++;
   endtask

   // Waits until every queued request has gone out and every response is back,
   // then lets the block settle for longer than a full clear-client scan.
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_requests.size() != 0 || req_bus.valid ||
                 lock_results_due.size() != 0);
      repeat (MAX_DEVICES + 4) @(negedge clock);
   endtask

   // The count register is only written with the block idle.
   task automatic write_device_count(logic [dlt_pkg::DEVCNT_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Request driver. An offered beat stays put until it is taken; after that the
   // sender may go quiet for a while before presenting the next queued request.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         tx_gap        <= 0;
         tx_stretch    <= 0;
         tx_calm       <= 1'b0;
      end else if (req_bus.valid && !req_bus.ready) begin
         // The current beat has not been taken yet, so everything holds.
      end else if (tx_gap != 0) begin
         tx_gap        <= tx_gap - 1;
         req_bus.valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
         tx_item              = pending_requests.pop_front();
         req_bus.valid        <= 1'b1;
         req_bus.opcode       <= tx_item.opcode;
         req_bus.device_index <= tx_item.device_index;
         req_bus.requester    <= tx_item.requester;
         if (tx_stretch == 0) begin
            tx_stretch <= $urandom_range(20, 80);
            tx_calm    <= ($urandom_range(0, 3) == 0);
         end else begin
            tx_stretch <= tx_stretch - 1;
         end
         tx_gap <= tx_calm ? 0 : idle_length();
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Response sink. Ready drops at random, and for a long stretch whenever the
   // stimulus asks for one, which fills the output register and stalls the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_gap        <= 0;
         rx_stretch    <= 0;
         rx_calm       <= 1'b0;
         rx_hold       <= 0;
         holds_granted <= 0;
      end else if (holds_granted != holds_asked) begin
         holds_granted <= holds_granted + 1;
         rx_hold       <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (rx_hold != 0) begin
         rx_hold       <= rx_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rx_gap != 0) begin
         rx_gap        <= rx_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (rx_stretch == 0) begin
            rx_stretch <= $urandom_range(20, 80);
            rx_calm    <= ($urandom_range(0, 3) == 0);
         end else begin
            rx_stretch <= rx_stretch - 1;
         end
         rx_gap <= rx_calm ? 0 : idle_length();
      end
   end

   // Monitor. A response is checked before the request of the same edge is
   // predicted, so a response with nothing owed is always caught as such.
   // The count register is mirrored at the edge where the block takes it.
   always @(posedge clock) begin
      if (reset) begin
         for (slot = 0; slot < MAX_DEVICES; slot++) begin
            entry_locked[slot] = 1'b0;
            entry_owner[slot]  = dlt_pkg::NO_OWNER;
         end
         device_count = dlt_pkg::DEVICES_RST;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (lock_results_due.size() == 0) begin
               $display("%0t: response beat with nothing expected, ok %0b owner %h",
                        $time, rsp_bus.ok, rsp_bus.owner);
               error_count++;
            end else begin
               due_rsp = lock_results_due.pop_front();
               if (rsp_bus.ok !== due_rsp.ok) begin
                  $display("%0t: ok mismatch, expected %0b, actual %0b",
                           $time, due_rsp.ok, rsp_bus.ok);
                  error_count++;
               end
               if (rsp_bus.owner !== due_rsp.owner) begin
                  $display("%0t: owner mismatch, expected %h, actual %h",
                           $time, due_rsp.owner, rsp_bus.owner);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_req.opcode       = dlt_pkg::op_type'(req_bus.opcode);
            seen_req.device_index = req_bus.device_index;
            seen_req.requester    = req_bus.requester;
            lock_results_due.push_back(predict_lock_result(seen_req));
         end
         if (csr_wr_en) begin
            device_count = csr_wr_data;
         end
      end
   end

   // Counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [dlt_pkg::DEVCNT_W-1:0]   plan [10];
      logic [dlt_pkg::CLIENT_W-1:0]   client_pool [4];
      logic [dlt_pkg::CLIENT_W-1:0]   who;
      int unsigned           p;
      int unsigned           target;
      int unsigned           effective;
      int unsigned           span;
      int unsigned           dev;
      int unsigned           kind;

      plan = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd9, 5'd17, 5'd4, 5'd16, 5'd12, 5'd31};

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, with the reset count of 16 entries.
      // A free entry: check reports it unlocked and unlock succeeds on it.
      queue_request(dlt_pkg::OP_CHECK, 0, 0);
      queue_request(dlt_pkg::OP_UNLOCK, 0, TAG_CLIENT);
      // Locking, relocking by the owner, and refusal for anyone else.
      queue_request(dlt_pkg::OP_TRYLOCK, 0, ALL_ONES);
      queue_request(dlt_pkg::OP_TRYLOCK, 0, ALL_ONES);
      queue_request(dlt_pkg::OP_TRYLOCK, 0, 0);
      queue_request(dlt_pkg::OP_CHECK, 0, 0);
      queue_request(dlt_pkg::OP_UNLOCK, 0, 0);
      // The invalid-owner pattern is an ordinary client id.
      queue_request(dlt_pkg::OP_TRYLOCK, MAX_DEVICES - 1, dlt_pkg::NO_OWNER);
      queue_request(dlt_pkg::OP_CHECK, MAX_DEVICES - 1, ALL_ONES);
      // Indices just past the count and at the top of the field fail.
      queue_request(dlt_pkg::OP_TRYLOCK, MAX_DEVICES, 0);
      queue_request(dlt_pkg::OP_CHECK, 63, ALL_ONES);
      // Clear-client releases every entry of the client, then finds nothing.
      queue_request(dlt_pkg::OP_TRYLOCK, 5, ALL_ONES);
      queue_request(dlt_pkg::OP_CLEAR, 63, ALL_ONES);
      queue_request(dlt_pkg::OP_CLEAR, 0, ALL_ONES);
      queue_request(dlt_pkg::OP_UNLOCK, MAX_DEVICES - 1, dlt_pkg::NO_OWNER);
      queue_request(dlt_pkg::OP_TRYLOCK, 3, TAG_CLIENT);
      queue_request(dlt_pkg::OP_TRYLOCK, 12, TAG_CLIENT);

      // Shrinking the count hides entry 12 but keeps it locked; the scan only
      // covers the entries still in use.
      write_device_count(5'd4);
      queue_request(dlt_pkg::OP_CHECK, 12, 0);
      queue_request(dlt_pkg::OP_CLEAR, 12, TAG_CLIENT);
      queue_request(dlt_pkg::OP_CHECK, 4, 0);

      // With no entries in use every request fails.
      write_device_count(5'd0);
      queue_request(dlt_pkg::OP_TRYLOCK, 0, TAG_CLIENT);
      queue_request(dlt_pkg::OP_CLEAR, 0, TAG_CLIENT);

      // A count above the table size acts as the full table, and the hidden
      // entry comes back with its old owner.
      write_device_count(5'd31);
      queue_request(dlt_pkg::OP_CHECK, 12, 0);
      queue_request(dlt_pkg::OP_CHECK, MAX_DEVICES, 0);
      queue_request(dlt_pkg::OP_UNLOCK, 12, TAG_CLIENT);

      // Random part. Each phase sets a count, then mostly runs lock sessions
      // (take, maybe a rival's attempt, maybe a check, then release, clear or keep)
      // from a small pool of clients so that owners collide, mixed with noise.
      for (p = 0; p < 10; p++) begin
         write_device_count(plan[p]);
         effective = (32'(plan[p]) > MAX_DEVICES) ? MAX_DEVICES : 32'(plan[p]);
         span      = (effective == 0) ? 1 : effective;
         target    = queued_total + ((effective == 0) ? 40 : 220);

         client_pool[0] = dlt_pkg::NO_OWNER;
         client_pool[1] = p[0] ? ALL_ONES : '0;
         client_pool[2] = $urandom;
         client_pool[3] = $urandom;

         // Once, the receiver stops for a long stretch while requests keep coming.
         if (p == 2) begin
            holds_asked++;
         end

         while (queued_total < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               who = client_pool[$urandom_range(0, 3)];
               dev = $urandom_range(0, span - 1);
               queue_request(dlt_pkg::OP_TRYLOCK, dev, who);
               if ($urandom_range(0, 2) == 0) begin
                  queue_request($urandom_range(0, 1) ? dlt_pkg::OP_TRYLOCK
                                                     : dlt_pkg::OP_UNLOCK, dev,
                                client_pool[$urandom_range(0, 3)]);
               end
               if ($urandom_range(0, 1) == 1) begin
                  queue_request(dlt_pkg::OP_CHECK, dev, $urandom);
               end
               case ($urandom_range(0, 3))
                  0, 1: begin
                     queue_request(dlt_pkg::OP_UNLOCK, dev, who);
                  end
                  2: begin
                     queue_request(dlt_pkg::OP_CLEAR, $urandom_range(0, 63), who);
                  end
                  default: begin
                     // The lock stays held into later sessions.
                  end
               endcase
            end else begin
               dev = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, span + 1);
               who = ($urandom_range(0, 1) == 1) ? client_pool[$urandom_range(0, 3)]
                                                 : $urandom;
               queue_request(dlt_pkg::op_type'($urandom_range(0, 3)), dev, who);
            end
         end
      end

      // Drain: every response must arrive, and nothing may follow it.
      wait_idle();
      repeat (MAX_DEVICES + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/dlt_pkg.sv
hw/rtl/dlt_req_if.sv
hw/rtl/dlt_rsp_if.sv
hw/rtl/device_lock_table.sv
verif/tb_device_lock_table.sv
